### rtl/core/assert_macros.svh
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds on every enabled clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent on one edge implies consequent on the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/scc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int COUNT_BITS  = 16;
	localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FILL_BITS   = $clog2(TABLE_DEPTH + 1);
	localparam int KIND_BITS   = 2;
	localparam int CH_BITS     = 8;
	localparam int COLOR_BITS  = 3 * CH_BITS;
	localparam int POS_BITS    = 8;
	localparam int CMP_BITS    = IDX_BITS + POS_BITS;
	localparam int GROUP_SIZE  = 16;
	localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

	localparam logic [CH_BITS-1:0]    CH_MAX      = 8'hff;
	localparam logic [COLOR_BITS-1:0] WHITE_COLOR = {3{CH_MAX}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE   = COUNT_BITS'(1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
	localparam logic [FILL_BITS-1:0]  FILL_ONE    = FILL_BITS'(1);
	localparam logic [FILL_BITS-1:0]  FILL_FULL   = FILL_BITS'(TABLE_DEPTH);

	typedef enum logic [KIND_BITS-1:0] {
		KIND_ADD   = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef struct packed {
		logic                  compare;
		logic                  clear;
		logic                  insert;
		logic                  bump;
		logic                  read;
		logic [COLOR_BITS-1:0] key_cmp;
		logic [COLOR_BITS-1:0] key_ins;
	} cell_ctrl_t;

	typedef struct packed {
		logic                  valid;
		logic [COLOR_BITS-1:0] color;
		logic [COUNT_BITS-1:0] count;
		logic                  lt;
	} cell_state_t;

	typedef struct packed {
		logic                  sel;
		logic [COLOR_BITS-1:0] color;
		logic [COUNT_BITS-1:0] count;
	} cell_rep_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]   idx;
		logic [COLOR_BITS-1:0] color;
		logic [COUNT_BITS-1:0] count;
	} tally_t;

	localparam cell_state_t LEFT_EDGE = '{valid: 1'b0, color: '0, count: '0, lt: 1'b1};

endpackage
`default_nettype wire

### rtl/core/scc_item_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface scc_item_if import scc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KIND_BITS-1:0] kind;
	logic [CH_BITS-1:0]   red;
	logic [CH_BITS-1:0]   green;
	logic [CH_BITS-1:0]   blue;
	logic [POS_BITS-1:0]  entry_index;

	modport source (output valid, kind, red, green, blue, entry_index, input ready);
	modport sink (input valid, kind, red, green, blue, entry_index, output ready);
endinterface
`default_nettype wire

### rtl/core/scc_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface scc_result_if import scc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic                  full_res;
	logic [POS_BITS-1:0]   position;
	logic [CH_BITS-1:0]    entry_red;
	logic [CH_BITS-1:0]    entry_green;
	logic [CH_BITS-1:0]    entry_blue;
	logic [COUNT_BITS-1:0] entry_count;
	logic [FILL_BITS-1:0]  used_entries;

	modport source (output valid, hit, full_res, position, entry_red, entry_green, entry_blue,
		entry_count, used_entries, input ready);
	modport sink (input valid, hit, full_res, position, entry_red, entry_green, entry_blue,
		entry_count, used_entries, output ready);
endinterface
`default_nettype wire

### rtl/core/scc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module scc_cell import scc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        first,
	input  cell_ctrl_t  ctrl,
	input  cell_state_t left,
	input  logic        read_sel,
	output cell_state_t state,
	output logic        eq_now,
	output cell_rep_t   rep
);

	logic                  valid_q;
	logic                  lt_q;
	logic                  eq_q;
	logic [COLOR_BITS-1:0] color_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  sel;

	assign eq_now = valid_q && (color_q == ctrl.key_cmp);
	// first entry not below the key
	assign sel = left.lt && !lt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= first;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
			color_q <= WHITE_COLOR;
			count_q <= COUNT_ONE;
		end else begin
			if (ctrl.compare) begin
				lt_q <= valid_q && (color_q < ctrl.key_cmp);
				eq_q <= eq_now;
			end
			if (ctrl.clear) begin
				valid_q <= first;
				color_q <= WHITE_COLOR;
				count_q <= COUNT_ONE;
			end else if (ctrl.insert) begin
				if (sel) begin
					valid_q <= 1'b1;
					color_q <= ctrl.key_ins;
					count_q <= COUNT_ONE;
				end else if (!left.lt && left.valid) begin
					valid_q <= 1'b1;
					color_q <= left.color;
					count_q <= left.count;
				end
			end else if (ctrl.bump && eq_q && (count_q != COUNT_MAX)) begin
				count_q <= count_q + COUNT_ONE;
			end
		end
	end

	assign state = '{valid: valid_q, color: color_q, count: count_q, lt: lt_q};

	always_comb begin
		rep.sel   = ctrl.read ? (valid_q && read_sel) : sel;
		rep.color = color_q;
		rep.count = count_q;
	end

endmodule
`default_nettype wire

### rtl/core/scc_collect.sv
`timescale 1ns / 1ps
`default_nettype none
module scc_collect import scc_pkg::*; (
	input  logic                   clk,
	input  logic                   hit_load,
	input  logic [TABLE_DEPTH-1:0] eq_vec,
	input  logic                   rep_load,
	input  cell_rep_t              rep [TABLE_DEPTH],
	output logic                   hit,
	output tally_t                 merged
);

	localparam int PAD_DEPTH = NUM_GROUPS * GROUP_SIZE;

	logic [PAD_DEPTH-1:0]  eq_pad;
	tally_t                masked [PAD_DEPTH];
	logic [NUM_GROUPS-1:0] grp_hit_q;
	tally_t                grp_q [NUM_GROUPS];

	for (genvar i = 0; i < PAD_DEPTH; i++) begin : g_pad
		if (i < TABLE_DEPTH) begin : g_cell
			assign eq_pad[i] = eq_vec[i];
			assign masked[i] = rep[i].sel ?
				'{idx: IDX_BITS'(i), color: rep[i].color, count: rep[i].count} : '0;
		end else begin : g_none
			assign eq_pad[i] = 1'b0;
			assign masked[i] = '0;
		end
	end

	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
		logic   grp_hit_d;
		tally_t grp_d;

		always_comb begin
			grp_hit_d = |eq_pad[g*GROUP_SIZE +: GROUP_SIZE];
			grp_d = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				grp_d = grp_d | masked[g*GROUP_SIZE + k];
			end
		end

		always_ff @(posedge clk) begin
			if (hit_load) begin
				grp_hit_q[g] <= grp_hit_d;
			end
			if (rep_load) begin
				grp_q[g] <= grp_d;
			end
		end
	end

	always_comb begin
		hit = |grp_hit_q;
		merged = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			merged = merged | grp_q[g];
		end
	end

endmodule
`default_nettype wire

### rtl/core/sorted_color_count_table.sv
// channel  | dir | payload                                            | handshake
// items    | in  | kind, red, green, blue, entry_index                | valid/ready
// results  | out | hit, full_res, position, entry_red/green/blue,     | valid/ready
//          |     | entry_count, used_entries                          |
//
// An item passes a compare step, where every cell compares against the key, then an
// update step, where the group hit flags merge and the cell row shifts, bumps or clears
// in a single step, then a merge of the group registers into the result register,
// overlapped with the next item's compare. Items are not taken while one is in compare.
// After reset the table holds one entry, white with count 1.
// A held result stalls the merge stage, then the update stage, then the input.
`timescale 1ns / 1ps
`default_nettype none
module sorted_color_count_table import scc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	scc_item_if.sink       items,
	scc_result_if.source   results
);

	`include "assert_macros.svh"

	logic                  vld_s1, vld_s2, vld_s3;
	kind_t                 kind_s1, kind_s2, kind_s3;
	logic [COLOR_BITS-1:0] key_s1, key_s2, key_s3;
	logic [POS_BITS-1:0]   index_s1, index_s2, index_s3;
	logic                  hit_s3, full_s3;
	logic [FILL_BITS-1:0]  fill_s3;
	logic [FILL_BITS-1:0]  fill_q, fill_d;

	logic accept, u_adv, t_adv;
	logic is_add, full, hit;
	cell_ctrl_t ctrl;

	cell_state_t            st [TABLE_DEPTH];
	cell_rep_t              rep [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] eq_vec, read_sel, valid_vec;
	tally_t                 merged;

	logic                  out_vld_q;
	logic                  res_hit_q, res_full_q;
	logic [POS_BITS-1:0]   res_pos_q;
	logic [COLOR_BITS-1:0] res_color_q;
	logic [COUNT_BITS-1:0] res_count_q;
	logic [FILL_BITS-1:0]  res_used_q;

	logic                  res_hit_d, res_full_d;
	logic [POS_BITS-1:0]   res_pos_d;
	logic [COLOR_BITS-1:0] res_color_d;
	logic [COUNT_BITS-1:0] res_count_d;

	assign t_adv = vld_s3 && (!out_vld_q || results.ready);
	assign u_adv = vld_s2 && (!vld_s3 || t_adv);
	assign items.ready = !vld_s1 && (!vld_s2 || u_adv);
	assign accept = items.valid && items.ready;

	assign is_add = (kind_s2 == KIND_ADD);
	assign full = (fill_q == FILL_FULL);

	always_comb begin
		ctrl.compare = vld_s1;
		ctrl.clear   = u_adv && (kind_s2 == KIND_CLEAR);
		ctrl.insert  = u_adv && is_add && !hit && !full;
		ctrl.bump    = u_adv && is_add && hit;
		ctrl.read    = (kind_s2 == KIND_READ);
		ctrl.key_cmp = key_s1;
		ctrl.key_ins = key_s2;
	end

	always_comb begin
		fill_d = fill_q;
		if (ctrl.clear) begin
			fill_d = FILL_ONE;
		end else if (ctrl.insert) begin
			fill_d = fill_q + FILL_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
			fill_q    <= FILL_ONE;
		end else begin
			vld_s1    <= accept;
			vld_s2    <= vld_s1 || (vld_s2 && !u_adv);
			vld_s3    <= u_adv || (vld_s3 && !t_adv);
			out_vld_q <= t_adv || (out_vld_q && !results.ready);
			fill_q    <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_t'(items.kind);
			key_s1   <= {items.red, items.green, items.blue};
			index_s1 <= items.entry_index;
		end
		if (vld_s1) begin
			kind_s2  <= kind_s1;
			key_s2   <= key_s1;
			index_s2 <= index_s1;
		end
		if (u_adv) begin
			kind_s3  <= kind_s2;
			key_s3   <= key_s2;
			index_s3 <= index_s2;
			hit_s3   <= hit;
			full_s3  <= full;
			fill_s3  <= fill_d;
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cell_state_t left;

		if (i == 0) begin : g_head
			assign left = LEFT_EDGE;
		end else begin : g_body
			assign left = st[i-1];
		end

		assign read_sel[i]  = (CMP_BITS'(index_s2) == CMP_BITS'(i));
		assign valid_vec[i] = st[i].valid;

		scc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.first    (1'(i == 0)),
			.ctrl     (ctrl),
			.left     (left),
			.read_sel (read_sel[i]),
			.state    (st[i]),
			.eq_now   (eq_vec[i]),
			.rep      (rep[i])
		);
	end

	scc_collect u_collect (
		.clk      (clk),
		.hit_load (vld_s1),
		.eq_vec   (eq_vec),
		.rep_load (u_adv),
		.rep      (rep),
		.hit      (hit),
		.merged   (merged)
	);

	always_comb begin
		res_hit_d   = 1'b0;
		res_full_d  = 1'b0;
		res_pos_d   = '0;
		res_color_d = '0;
		res_count_d = '0;
		case (kind_s3)
			KIND_ADD: begin
				if (hit_s3) begin
					res_hit_d   = 1'b1;
					res_pos_d   = POS_BITS'(merged.idx);
					res_color_d = key_s3;
					res_count_d = (merged.count == COUNT_MAX) ? COUNT_MAX
						: merged.count + COUNT_ONE;
				end else if (full_s3) begin
					res_full_d = 1'b1;
				end else begin
					res_pos_d   = POS_BITS'(merged.idx);
					res_color_d = key_s3;
					res_count_d = COUNT_ONE;
				end
			end
			KIND_READ: begin
				res_pos_d   = index_s3;
				res_color_d = merged.color;
				res_count_d = merged.count;
			end
			KIND_CLEAR: begin
				res_color_d = WHITE_COLOR;
				res_count_d = COUNT_ONE;
			end
			default: begin
				res_hit_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (t_adv) begin
			res_hit_q   <= res_hit_d;
			res_full_q  <= res_full_d;
			res_pos_q   <= res_pos_d;
			res_color_q <= res_color_d;
			res_count_q <= res_count_d;
			res_used_q  <= fill_s3;
		end
	end

	assign results.valid        = out_vld_q;
	assign results.hit          = res_hit_q;
	assign results.full_res     = res_full_q;
	assign results.position     = res_pos_q;
	assign results.entry_red    = res_color_q[COLOR_BITS-1 -: CH_BITS];
	assign results.entry_green  = res_color_q[CH_BITS +: CH_BITS];
	assign results.entry_blue   = res_color_q[CH_BITS-1:0];
	assign results.entry_count  = res_count_q;
	assign results.used_entries = res_used_q;

	`ASSERT_ALWAYS(a_cmp_upd_excl, clk, arst_n, !(vld_s1 && vld_s2), "compare overlaps update")
	`ASSERT_ALWAYS(a_valid_fill, clk, arst_n, $countones(valid_vec) == fill_q, "valid cells differ from fill level")
	`ASSERT_ALWAYS(a_head_valid, clk, arst_n, st[0].valid, "first cell empty")
	`ASSERT_NEXT(a_fill_step, clk, arst_n, ctrl.insert, fill_q == $past(fill_q) + FILL_ONE, "insert did not grow table")

endmodule
`default_nettype wire

### verif/sorted_color_count_table_tb.sv
`timescale 1ns / 1ps
module sorted_color_count_table_tb import scc_pkg::*; ();

	localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [CH_BITS-1:0]   red;
		logic [CH_BITS-1:0]   green;
		logic [CH_BITS-1:0]   blue;
		logic [POS_BITS-1:0]  entry_index;
	} color_item_t;

	typedef struct packed {
		logic                  hit;
		logic                  full_res;
		logic [POS_BITS-1:0]   position;
		logic [CH_BITS-1:0]    entry_red;
		logic [CH_BITS-1:0]    entry_green;
		logic [CH_BITS-1:0]    entry_blue;
		logic [COUNT_BITS-1:0] entry_count;
		logic [FILL_BITS-1:0]  used_entries;
	} table_reply_t;

	typedef enum {MIX_PALETTE, MIX_FILL, MIX_NOISE} mix_t;

	class color_tally_board;
		logic [COLOR_BITS-1:0] colors [TABLE_DEPTH];
		logic [COUNT_BITS-1:0] tallies [TABLE_DEPTH];
		int unsigned used;
		table_reply_t pending [$];
		int errors;

		function new();
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (colors[i]) begin
				colors[i] = '0;
				tallies[i] = '0;
			end
			colors[0] = WHITE_COLOR;
			tallies[0] = COUNT_ONE;
			used = 1;
		endfunction

		function table_reply_t apply_item(color_item_t it);
			table_reply_t r;
			logic [COLOR_BITS-1:0] key;
			int unsigned pos;
			int unsigned i;
			r = '0;
			key = {it.red, it.green, it.blue};
			pos = 0;
			case (it.kind)
			KIND_ADD: begin
				while (pos < used && colors[pos] < key)
					pos++;
				if (pos < used && colors[pos] == key) begin
					if (tallies[pos] != COUNT_MAX)
						tallies[pos]++;
					r.hit = 1'b1;
					r.position = POS_BITS'(pos);
					{r.entry_red, r.entry_green, r.entry_blue} = key;
					r.entry_count = tallies[pos];
				end else if (used >= TABLE_DEPTH) begin
					r.full_res = 1'b1;
				end else begin
					for (i = used; i > pos; i--) begin
						colors[i] = colors[i - 1];
						tallies[i] = tallies[i - 1];
					end
					colors[pos] = key;
					tallies[pos] = COUNT_ONE;
					used++;
					r.position = POS_BITS'(pos);
					{r.entry_red, r.entry_green, r.entry_blue} = key;
					r.entry_count = COUNT_ONE;
				end
			end
			KIND_READ: begin
				r.position = it.entry_index;
				if (it.entry_index < used) begin
					{r.entry_red, r.entry_green, r.entry_blue} = colors[it.entry_index];
					r.entry_count = tallies[it.entry_index];
				end
			end
			KIND_CLEAR: begin
				wipe();
				{r.entry_red, r.entry_green, r.entry_blue} = WHITE_COLOR;
				r.entry_count = COUNT_ONE;
			end
			default: ;
			endcase
			r.used_entries = FILL_BITS'(used);
			return r;
		endfunction

		task report(input string what, input longint unsigned got, input longint unsigned want);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		endtask

		task note_item(input color_item_t it);
			pending = {pending, apply_item(it)};
		endtask

		task check_result(input table_reply_t got);
			table_reply_t want;
			if (pending.size() == 0) begin
				report("result with no item pending", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.hit !== want.hit)
				report("hit", got.hit, want.hit);
			if (got.full_res !== want.full_res)
				report("full_res", got.full_res, want.full_res);
			if (got.position !== want.position)
				report("position", got.position, want.position);
			if (got.entry_red !== want.entry_red)
				report("entry_red", got.entry_red, want.entry_red);
			if (got.entry_green !== want.entry_green)
				report("entry_green", got.entry_green, want.entry_green);
			if (got.entry_blue !== want.entry_blue)
				report("entry_blue", got.entry_blue, want.entry_blue);
			if (got.entry_count !== want.entry_count)
				report("entry_count", got.entry_count, want.entry_count);
			if (got.used_entries !== want.used_entries)
				report("used_entries", got.used_entries, want.used_entries);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;
	int   hold_pending;
	int   hold_left;
	int   stalled;
	color_tally_board board = new();

	scc_item_if   items_if();
	scc_result_if results_if();

	sorted_color_count_table u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			board.check_result({results_if.hit, results_if.full_res, results_if.position,
				results_if.entry_red, results_if.entry_green, results_if.entry_blue,
				results_if.entry_count, results_if.used_entries});
		if (arst_n && items_if.valid && items_if.ready)
			board.note_item({items_if.kind, items_if.red, items_if.green, items_if.blue,
				items_if.entry_index});
	end

	// result side: random stalls, plus one long hold on request
	initial begin
		hold_left = 0;
		results_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_pending != 0) begin
				hold_left = HOLD_CYCLES;
				hold_pending = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else if (steady) begin
				results_if.ready <= 1'b1;
			end else begin
				results_if.ready <= ($urandom_range(99) >= 20);
			end
		end
	end

	initial begin
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("sorted_color_count_table test failed");
		$finish;
	end

	task automatic offer(input color_item_t it);
		if (!steady && $urandom_range(99) < 20) begin
			items_if.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		items_if.valid       <= 1'b1;
		items_if.kind        <= it.kind;
		items_if.red         <= it.red;
		items_if.green       <= it.green;
		items_if.blue        <= it.blue;
		items_if.entry_index <= it.entry_index;
		do
			@(posedge clk);
		while (!items_if.ready);
	endtask

	task automatic offer_fields(input logic [KIND_BITS-1:0] kind, input logic [CH_BITS-1:0] r,
		input logic [CH_BITS-1:0] g, input logic [CH_BITS-1:0] b,
		input logic [POS_BITS-1:0] idx);
		offer({kind, r, g, b, idx});
	endtask

	function automatic logic [CH_BITS-1:0] pick_channel(input bit coarse);
		if (coarse) begin
			case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'h7f;
			3: return 8'h80;
			4: return 8'hfe;
			default: return CH_MAX;
			endcase
		end
		case ($urandom_range(9))
		0: return 8'h00;
		1: return CH_MAX;
		default: return CH_BITS'($urandom_range(255));
		endcase
	endfunction

	function automatic color_item_t make_item(input mix_t mix, input int unsigned fill);
		color_item_t it;
		int roll;
		bit coarse;
		roll = $urandom_range(99);
		it.entry_index = POS_BITS'($urandom_range(255));
		case (mix)
		MIX_PALETTE: begin
			coarse = 1'b1;
			if (roll < 60)
				it.kind = KIND_ADD;
			else if (roll < 90)
				it.kind = KIND_READ;
			else if (roll < 95)
				it.kind = KIND_CLEAR;
			else
				it.kind = KIND_UNUSED;
		end
		MIX_FILL: begin
			coarse = (roll < 8);
			it.kind = (roll < 85) ? KIND_ADD : KIND_READ;
		end
		default: begin
			coarse = 1'b0;
			it.kind = KIND_BITS'($urandom_range(3));
		end
		endcase
		it.red = pick_channel(coarse);
		it.green = pick_channel(coarse);
		it.blue = pick_channel(coarse);
		if (it.kind == KIND_READ && $urandom_range(3) != 0) begin
			if (fill < TABLE_DEPTH && $urandom_range(3) == 0)
				it.entry_index = POS_BITS'($urandom_range(255, fill));
			else
				it.entry_index = POS_BITS'($urandom_range(fill - 1));
		end
		return it;
	endfunction

	task automatic run_mix(input mix_t mix, input int n);
		repeat (n) offer(make_item(mix, board.used));
	endtask

	// clear, fill to the top, then keep adding against a full table
	task automatic fill_and_overflow();
		int past_full;
		past_full = 0;
		offer_fields(KIND_CLEAR, '0, '0, '0, '0);
		while (past_full < 40) begin
			offer(make_item(MIX_FILL, board.used));
			if (board.used >= TABLE_DEPTH)
				past_full++;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		steady = 1'b0;
		hold_pending = 0;
		items_if.valid       <= 1'b0;
		items_if.kind        <= KIND_ADD;
		items_if.red         <= '0;
		items_if.green       <= '0;
		items_if.blue        <= '0;
		items_if.entry_index <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_fields(KIND_READ, '0, '0, '0, 8'd0);
		offer_fields(KIND_READ, '0, '0, '0, 8'd1);
		offer_fields(KIND_READ, CH_MAX, CH_MAX, CH_MAX, 8'd255);
		offer_fields(KIND_ADD, CH_MAX, CH_MAX, CH_MAX, 8'd255);
		offer_fields(KIND_ADD, 8'h00, 8'h00, 8'h00, 8'd0);
		offer_fields(KIND_ADD, CH_MAX, CH_MAX, 8'hfe, 8'd0);
		offer_fields(KIND_ADD, 8'h00, 8'h00, 8'h00, 8'd0);
		offer_fields(KIND_ADD, 8'h00, 8'h00, 8'h01, 8'd0);
		offer_fields(KIND_READ, '0, '0, '0, 8'd3);
		offer_fields(KIND_READ, '0, '0, '0, 8'd4);
		offer_fields(KIND_UNUSED, CH_MAX, CH_MAX, CH_MAX, 8'd255);
		offer_fields(KIND_CLEAR, CH_MAX, CH_MAX, CH_MAX, 8'd255);
		offer_fields(KIND_READ, '0, '0, '0, 8'd1);
		offer_fields(KIND_ADD, 8'h80, 8'h00, CH_MAX, 8'd0);
		offer_fields(KIND_ADD, 8'h7f, CH_MAX, CH_MAX, 8'd0);
		offer_fields(KIND_ADD, 8'h80, 8'h00, 8'hfe, 8'd0);
		offer_fields(KIND_READ, '0, '0, '0, 8'd2);
		offer_fields(KIND_UNUSED, 8'h00, 8'h00, 8'h00, 8'd0);
		offer_fields(KIND_CLEAR, 8'h00, 8'h00, 8'h00, 8'd0);

		// back-to-back hits on one color
		steady = 1'b1;
		repeat (40) offer_fields(KIND_ADD, 8'h12, 8'h34, 8'h56, 8'd0);
		offer_fields(KIND_READ, '0, '0, '0, 8'd0);
		offer_fields(KIND_READ, '0, '0, '0, 8'd1);
		steady = 1'b0;

		run_mix(MIX_PALETTE, 200);
		fill_and_overflow();
		run_mix(MIX_NOISE, 100);
		hold_pending = 1;
		fill_and_overflow();
		steady = 1'b1;
		run_mix(MIX_PALETTE, 150);
		steady = 1'b0;
		run_mix(MIX_NOISE, 60);
		run_mix(MIX_PALETTE, 60);

		items_if.valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("sorted_color_count_table test passed");
		else
			$display("sorted_color_count_table test failed");
		$finish;
	end

endmodule
